FILE: hdl/rss_pkg.sv
package rss_pkg;

  localparam int unsigned CordicSteps = 24;
  localparam int unsigned CordicGain  = 652032874;
  localparam int unsigned OneQ30      = 1073741824;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    RegPhaseInc = 3'd0,
    RegRampLen  = 3'd1,
    RegRampInc  = 3'd2,
    RegEScale   = 3'd3,
    RegHScale   = 3'd4
  } reg_idx_e;

  // cordic arctangent table, 2^-32 turn
  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0:  r = 32'd536870912;
        5'd1:  r = 32'd316933406;
        5'd2:  r = 32'd167458907;
        5'd3:  r = 32'd85004756;
        5'd4:  r = 32'd42667331;
        5'd5:  r = 32'd21354465;
        5'd6:  r = 32'd10679838;
        5'd7:  r = 32'd5340245;
        5'd8:  r = 32'd2670163;
        5'd9:  r = 32'd1335087;
        5'd10: r = 32'd667544;
        5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;
        5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;
        5'd15: r = 32'd20861;
        5'd16: r = 32'd10430;
        5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;
        5'd19: r = 32'd1304;
        5'd20: r = 32'd652;
        5'd21: r = 32'd326;
        5'd22: r = 32'd163;
        5'd23: r = 32'd81;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

endpackage

FILE: hdl/rss_if.sv
interface rss_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] time_step;
  logic        magnetic;
  logic [23:0] amplitude;
  logic [31:0] phase;
  modport source (output valid, time_step, magnetic, amplitude, phase, input ready);
  modport sink (input valid, time_step, magnetic, amplitude, phase, output ready);
endinterface

interface rss_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] correction;
  modport source (output valid, correction, input ready);
  modport sink (input valid, correction, output ready);
endinterface

FILE: hdl/ramped_sine_source_value.sv
// throughput: one beat per cycle; the whole datapath stalls as one when the output waits
// one cordic iteration per stage for both carrier and ramp, plus angle, ramp, product stages
// reset: rst_ni clears all valid bits and the configuration registers to zero
// payload registers are not reset
module ramped_sine_source_value #(
  parameter int unsigned PHASE_BITS = 32,
  parameter int unsigned STEP_BITS  = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  rss_in_if.sink      in_if,
  rss_out_if.source   out_if
);

  localparam int unsigned NS = rss_pkg::CordicSteps;
  // stages: 0 angle, 1..NS cordic, NS+1 quadrant, NS+2 ramp mult, NS+3 ramp shift,
  // NS+4 amp*scale, NS+5 partial products, NS+6 sum, NS+7 output
  localparam int unsigned NST = NS + 8;
  localparam logic [31:0] Keep = 32'hFFFF_FFFF << (32 - PHASE_BITS);
  // step bits kept from the 24-bit time step field
  localparam logic [23:0] StepMask = 24'((64'd1 << STEP_BITS) - 64'd1);

  logic [31:0] phase_inc_q, ramp_inc_q, e_scale_q, h_scale_q;
  logic [23:0] ramp_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_inc_q <= '0;
      ramp_len_q  <= '0;
      ramp_inc_q  <= '0;
      e_scale_q   <= '0;
      h_scale_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rss_pkg::RegPhaseInc: phase_inc_q <= cfg_data_i;
        rss_pkg::RegRampLen:  ramp_len_q  <= cfg_data_i[23:0];
        rss_pkg::RegRampInc:  ramp_inc_q  <= cfg_data_i;
        rss_pkg::RegEScale:   e_scale_q   <= cfg_data_i;
        rss_pkg::RegHScale:   h_scale_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // one global enable: stages advance when the last stage is free
  logic [NST-1:0] vld_q;
  logic adv;
  assign adv = !vld_q[NST-1] || out_if.ready;
  assign in_if.ready = adv;
  assign out_if.valid = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[NST-2:0], in_if.valid};
  end

  // side info carried along the cordic
  logic        mag_q  [NS+4];
  logic        ramp_q [NS+3];
  logic [23:0] amp_q  [NS+4];
  logic [1:0]  cq_q   [NS+1];
  logic [1:0]  rq_q   [NS+1];
  logic signed [33:0] cx_q [NS+1], cy_q [NS+1], rx_q [NS+1], ry_q [NS+1];
  logic signed [33:0] cz_q [NS+1], rz_q [NS+1];

  // stage 0: angles
  logic [23:0] step_w;
  logic [24:0] n_w;
  logic [32:0] pt_w, rt_w;
  logic [31:0] pa_w, ra_w;
  assign step_w = in_if.time_step & StepMask;
  assign n_w  = {step_w, in_if.magnetic};
  assign pt_w = 33'(phase_inc_q * n_w);
  assign rt_w = 33'(ramp_inc_q * n_w);
  assign pa_w = (pt_w[32:1] + in_if.phase) & Keep;
  assign ra_w = rt_w[32:1] & Keep;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag_q[0]  <= in_if.magnetic;
      amp_q[0]  <= in_if.amplitude;
      ramp_q[0] <= (step_w < ramp_len_q);
      cq_q[0] <= pa_w[31:30];
      rq_q[0] <= ra_w[31:30];
      cx_q[0] <= 34'(rss_pkg::CordicGain);
      rx_q[0] <= 34'(rss_pkg::CordicGain);
      cy_q[0] <= '0;
      ry_q[0] <= '0;
      cz_q[0] <= {4'd0, pa_w[29:0]};
      rz_q[0] <= {4'd0, ra_w[29:0]};
    end
  end

  // cordic iterations, one per stage; >>> floors
  for (genvar i = 0; i < NS; i++) begin : g_cordic
    logic signed [33:0] at;
    assign at = 34'(rss_pkg::atan_turns(5'(i)));
    always_ff @(posedge clk_i) begin
      if (adv) begin
        mag_q[i+1]  <= mag_q[i];
        amp_q[i+1]  <= amp_q[i];
        ramp_q[i+1] <= ramp_q[i];
        cq_q[i+1]   <= cq_q[i];
        rq_q[i+1]   <= rq_q[i];
        if (!cz_q[i][33]) begin
          cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] - at;
        end else begin
          cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] + at;
        end
        if (!rz_q[i][33]) begin
          rx_q[i+1] <= rx_q[i] - (ry_q[i] >>> i);
          ry_q[i+1] <= ry_q[i] + (rx_q[i] >>> i);
          rz_q[i+1] <= rz_q[i] - at;
        end else begin
          rx_q[i+1] <= rx_q[i] + (ry_q[i] >>> i);
          ry_q[i+1] <= ry_q[i] - (rx_q[i] >>> i);
          rz_q[i+1] <= rz_q[i] + at;
        end
      end
    end
  end

  function automatic logic signed [31:0] clampq(input logic signed [33:0] v);
    logic signed [33:0] one;
    begin
      one = 34'(rss_pkg::OneQ30);
      if (v > one) return 32'(one);
      else if (v < -one) return 32'(-one);
      else return 32'(v);
    end
  endfunction

  // quadrant mapping
  logic signed [33:0] csn_w, rcs_w;
  always_comb begin
    case (cq_q[NS])
      2'd0: csn_w = cy_q[NS];
      2'd1: csn_w = cx_q[NS];
      2'd2: csn_w = -cy_q[NS];
      default: csn_w = -cx_q[NS];
    endcase
    case (rq_q[NS])
      2'd0: rcs_w = rx_q[NS];
      2'd1: rcs_w = -ry_q[NS];
      2'd2: rcs_w = -rx_q[NS];
      default: rcs_w = ry_q[NS];
    endcase
  end

  logic signed [31:0] s1_q, w1_q;
  logic signed [62:0] sw_q;
  logic signed [31:0] s2_q, s3_q;
  logic [55:0] p_q;
  logic [30:0] m_q;
  logic        neg_q;
  logic [54:0] pa_q, pb_q;
  logic [45:0] q_q;
  logic        neg2_q, neg3_q;
  logic [31:0] res_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // quadrant and clamp
      s1_q <= clampq(csn_w);
      w1_q <= 32'((34'(rss_pkg::OneQ30) - 34'(clampq(rcs_w))) >>> 1);
      mag_q[NS+1] <= mag_q[NS];
      amp_q[NS+1] <= amp_q[NS];
      ramp_q[NS+1] <= ramp_q[NS];
      // ramp multiply
      sw_q <= 63'(s1_q) * 63'(w1_q);
      s2_q <= s1_q;
      mag_q[NS+2] <= mag_q[NS+1];
      amp_q[NS+2] <= amp_q[NS+1];
      ramp_q[NS+2] <= ramp_q[NS+1];
      // ramp select
      s3_q <= ramp_q[NS+2] ? 32'(sw_q >>> 30) : s2_q;
      mag_q[NS+3] <= mag_q[NS+2];
      amp_q[NS+3] <= amp_q[NS+2];
      // amplitude times scale
      p_q <= 56'(amp_q[NS+3]) * 56'(mag_q[NS+3] ? h_scale_q : e_scale_q);
      m_q <= s3_q[31] ? 31'(-s3_q) : 31'(s3_q);
      neg_q <= s3_q[31];
      // partial products, |s| <= 2^30
      pa_q <= 55'(p_q[55:32] * m_q);
      pb_q <= 55'((63'(p_q[31:0]) * 63'(m_q)) >> 32);
      neg2_q <= neg_q;
      // sum and shift, magnitude up to 44 bits
      q_q <= 46'((56'(pa_q) + 56'(pb_q)) >> 10);
      neg3_q <= neg2_q;
      // saturate
      if (neg3_q) res_q <= (q_q > 46'h0_8000_0000) ? 32'h8000_0000 : 32'd0 - q_q[31:0];
      else res_q <= (q_q > 46'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q_q[31:0];
    end
  end

  assign out_if.correction = res_q;

endmodule

FILE: verif/tb_ramped_sine_source_value.sv
module tb_ramped_sine_source_value;

  localparam int Latency = 32;
  localparam int WatchdogLimit = 20000;

  typedef struct packed {
    logic [23:0] time_step;
    logic        magnetic;
    logic [23:0] amplitude;
    logic [31:0] phase;
  } src_beat_t;

  // idling phases
  typedef enum int {PhNone, PhSendIdle, PhRecvStall, PhBoth} idle_ph_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  rss_in_if  in_if ();
  rss_out_if out_if ();

  ramped_sine_source_value dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_if(in_if.sink), .out_if(out_if.source)
  );

  always #5 clk_i = ~clk_i;

  // own copy of the configuration
  logic [31:0] m_phase_inc, m_ramp_inc, m_e_scale, m_h_scale;
  logic [23:0] m_ramp_len;

  src_beat_t pending_q[$];
  logic [31:0] correction_q[$];
  int errors = 0;
  int n_in = 0, n_out = 0, n_ramped = 0, n_sat = 0;
  idle_ph_e phase_mode = PhNone;
  bit hold_recv = 1'b0;
  bit drv_pause = 1'b0;
  int idle_cnt = 0;

  initial begin
    in_if.valid = 1'b0;
    in_if.time_step = '0;
    in_if.magnetic = 1'b0;
    in_if.amplitude = '0;
    in_if.phase = '0;
    out_if.ready = 1'b0;
  end

  function automatic longint floor_sh(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint clamp30(longint v);
    if (v > longint'(rss_pkg::OneQ30)) return longint'(rss_pkg::OneQ30);
    if (v < -longint'(rss_pkg::OneQ30)) return -longint'(rss_pkg::OneQ30);
    return v;
  endfunction

  // cordic rotation with quadrant mapping, gives sin and cos in q30
  task automatic rotate(input logic [31:0] ang, output longint sn, output longint cs);
    longint x, y, z, dx, dy;
    logic [1:0] quad;
    x = 652032874;
    y = 0;
    z = longint'(ang[29:0]);
    quad = ang[31:30];
    for (int i = 0; i < 24; i++) begin
      dx = floor_sh(y, i);
      dy = floor_sh(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(rss_pkg::atan_turns(5'(i)));
      end else begin
        x += dx; y -= dy; z += longint'(rss_pkg::atan_turns(5'(i)));
      end
    end
    case (quad)
      2'd0: begin cs = x; sn = y; end
      2'd1: begin cs = -y; sn = x; end
      2'd2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
    sn = clamp30(sn);
    cs = clamp30(cs);
  endtask

  function automatic logic [31:0] angle_at(logic [31:0] inc, logic [25:0] n, logic [31:0] off);
    logic [63:0] t;
    t = 64'(inc) * 64'(n);
    return t[32:1] + off;
  endfunction

  // expected field correction for one sample
  task automatic predict_correction(input src_beat_t b, output logic [31:0] res);
    logic [25:0] n;
    longint s, c, rs, rc, w;
    logic [63:0] p, m, a, bb, q;
    n = {1'b0, b.time_step, 1'b0} + 26'(b.magnetic);
    rotate(angle_at(m_phase_inc, n, b.phase), s, c);
    if (b.time_step < m_ramp_len) begin
      rotate(angle_at(m_ramp_inc, n, 32'd0), rs, rc);
      w = (longint'(rss_pkg::OneQ30) - rc) >>> 1;
      s = floor_sh(s * w, 30);
      n_ramped++;
    end
    p = 64'(b.amplitude) * 64'(b.magnetic ? m_h_scale : m_e_scale);
    m = 64'(s < 0 ? -s : s);
    a = (p >> 32) * m;
    bb = (p & 64'hFFFF_FFFF) * m;
    q = (a + (bb >> 32)) >> 10;
    if (s < 0) begin
      if (q > 64'h8000_0000) begin q = 64'h8000_0000; n_sat++; end
      res = 32'd0 - q[31:0];
    end else begin
      if (q > 64'h7FFF_FFFF) begin q = 64'h7FFF_FFFF; n_sat++; end
      res = q[31:0];
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    errors++;
    $display("mismatch %s: got %h expected %h (beat %0d)", what, got, exp, n_out);
  endtask

  function automatic bit idle_now(bit sender);
    case (phase_mode)
      PhSendIdle:  return sender && ($urandom_range(99) < 86);
      PhRecvStall: return !sender && ($urandom_range(99) < 86);
      PhBoth:      return $urandom_range(99) < 6;
      default:     return 1'b0;
    endcase
  endfunction

  // driver: offers the head of the pending queue
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        logic [31:0] r;
        predict_correction(pending_q.pop_front(), r);
        correction_q.push_back(r);
        n_in++;
      end
      if ((in_if.valid && !in_if.ready) ||
          (pending_q.size() > 0 && !drv_pause && !idle_now(1'b1))) begin
        in_if.valid <= (pending_q.size() > 0);
        if (pending_q.size() > 0) begin
          in_if.time_step <= pending_q[0].time_step;
          in_if.magnetic  <= pending_q[0].magnetic;
          in_if.amplitude <= pending_q[0].amplitude;
          in_if.phase     <= pending_q[0].phase;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // monitor: checks result beats in order
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (correction_q.size() == 0) report("unexpected beat", out_if.correction, 32'd0);
        else begin
          logic [31:0] e;
          e = correction_q.pop_front();
          if (out_if.correction !== e) report("correction", out_if.correction, e);
        end
        n_out++;
      end
      out_if.ready <= !hold_recv && !idle_now(1'b0);
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WatchdogLimit) begin
      $display("watchdog expired, %0d results outstanding", correction_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_if.valid || correction_q.size() > 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(input rss_pkg::reg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      rss_pkg::RegPhaseInc: m_phase_inc = val;
      rss_pkg::RegRampLen:  m_ramp_len = val[23:0];
      rss_pkg::RegRampInc:  m_ramp_inc = val;
      rss_pkg::RegEScale:   m_e_scale = val;
      rss_pkg::RegHScale:   m_h_scale = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic setup(input logic [31:0] pi, input logic [31:0] rl, input logic [31:0] ri,
                       input logic [31:0] es, input logic [31:0] hs);
    wait_drained();
    write_reg(rss_pkg::RegPhaseInc, pi);
    write_reg(rss_pkg::RegRampLen, rl);
    write_reg(rss_pkg::RegRampInc, ri);
    write_reg(rss_pkg::RegEScale, es);
    write_reg(rss_pkg::RegHScale, hs);
    @(posedge clk_i);
  endtask

  function automatic src_beat_t rand_beat(logic [23:0] step_max);
    src_beat_t b;
    b.time_step = 24'($urandom_range(step_max));
    if ($urandom_range(9) == 0) b.time_step = 24'($urandom);
    b.magnetic = 1'($urandom);
    case ($urandom_range(3))
      0: b.amplitude = 24'($urandom);
      1: b.amplitude = 24'($urandom_range(4096));
      2: b.amplitude = $urandom_range(1) ? 24'hFFFFFF : 24'd0;
      default: b.amplitude = 24'($urandom_range(65535));
    endcase
    b.phase = $urandom;
    return b;
  endfunction

  function automatic src_beat_t mk(logic [23:0] t, logic m, logic [23:0] a, logic [31:0] p);
    src_beat_t b;
    b.time_step = t; b.magnetic = m; b.amplitude = a; b.phase = p;
    return b;
  endfunction

  initial begin
    m_phase_inc = '0; m_ramp_len = '0; m_ramp_inc = '0; m_e_scale = '0; m_h_scale = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // registers at reset value: everything must come out zero
    pending_q.push_back(mk(24'd5, 1'b0, 24'hFFFFFF, 32'h4000_0000));
    pending_q.push_back(mk(24'd6, 1'b1, 24'hFFFFFF, 32'hC000_0000));

    // directed: quadrant corners, extremes, saturation, both field types
    setup(32'h0100_0000, 32'd0, 32'd0, 32'h0001_0000, 32'h0002_0000);
    for (int q = 0; q < 4; q++) begin
      pending_q.push_back(mk(24'd0, 1'b0, 24'h001000, 32'(q) << 30));
      pending_q.push_back(mk(24'd0, 1'b1, 24'h001000, (32'(q) << 30) + 32'h2000_0000));
    end
    pending_q.push_back(mk(24'hFFFFFF, 1'b1, 24'hFFFFFF, 32'hFFFF_FFFF));
    pending_q.push_back(mk(24'd0, 1'b0, 24'd0, 32'h4000_0000));
    setup(32'hFFFF_FFFF, 32'h00FF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    pending_q.push_back(mk(24'd1, 1'b0, 24'hFFFFFF, 32'h4000_0000));  // positive carrier peak on a ramped step
    pending_q.push_back(mk(24'd1, 1'b0, 24'hFFFFFF, 32'hC000_0000));  // negative carrier peak on a ramped step
    pending_q.push_back(mk(24'hFFFFFE, 1'b1, 24'hFFFFFF, 32'h0));     // last ramped step
    pending_q.push_back(mk(24'hFFFFFF, 1'b0, 24'hFFFFFF, 32'h8000_0000)); // step at ramp end
    setup(32'h0123_4567, 32'd16, 32'h1000_0000, 32'h0000_8000, 32'h0003_0000);
    for (int t = 0; t < 18; t += 3) pending_q.push_back(mk(24'(t), 1'(t), 24'h00A000, 32'd0));
    wait_drained();
    write_reg(rss_pkg::RegRampLen, 32'hFF00_0010); // wide data is masked
    m_ramp_len = 24'h000010;
    pending_q.push_back(mk(24'd15, 1'b1, 24'h00A000, 32'h1234_5678));
    pending_q.push_back(mk(24'd16, 1'b0, 24'h00A000, 32'h1234_5678));

    // random part, one idling mode per block of items, new settings each phase
    for (int ph = 0; ph < 8; ph++) begin
      logic [23:0] rl;
      rl = (ph % 3 == 0) ? 24'd0 : 24'($urandom_range(200));
      setup($urandom, {8'd0, rl}, $urandom, $urandom >> $urandom_range(31),
            $urandom >> $urandom_range(31));
      phase_mode = idle_ph_e'(ph % 4);
      for (int k = 0; k < 85; k++) pending_q.push_back(rand_beat(24'(2 * rl + 2)));
      if (ph == 4) begin
        // long receiver hold-off while items keep coming
        hold_recv = 1'b1;
        repeat (200) @(posedge clk_i);
        hold_recv = 1'b0;
      end
      if (ph == 5) begin
        // sender pause until all results are in
        while (pending_q.size() > 40) @(posedge clk_i);
        drv_pause = 1'b1;
        @(posedge clk_i);
        while (in_if.valid || correction_q.size() > 0) @(posedge clk_i);
        drv_pause = 1'b0;
      end
    end
    phase_mode = PhNone;
    wait_drained();

    $display("%0d beats in, %0d results checked, %0d ramped, %0d saturated",
             n_in, n_out, n_ramped, n_sat);
    $display("config sweeps covered zero and full-scale registers and all idling modes");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
